/* hw/rtl/aging_slot_link_table_defines.svh */
// Assertion macros shared by the slot link table checkers.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef AGING_SLOT_LINK_TABLE_DEFINES_SVH
`define AGING_SLOT_LINK_TABLE_DEFINES_SVH

// Check on every clock edge outside reset.
`define ASLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASLT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/aslt_pkg.sv */
// Types and constants for the aging slot link table.
// Used by the age comparator, the top level and the checker; depends on nothing.
package aslt_pkg;

    localparam int HANDLE_W    = 32;
    localparam int STAMP_W     = 32;
    localparam int AGE_W       = 16;
    localparam int ID_W        = 8;
    localparam int IDX_OUT_W   = 5;

    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [STAMP_W-1:0]  t_stamp;
    typedef logic [AGE_W-1:0]    t_age;
    typedef logic [ID_W-1:0]     t_id;

    // one slot word as held in the slot RAM
    typedef struct packed {
        t_handle handle;
        t_stamp  stamp;
    } t_entry;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TAKE = 1'b1;

    localparam t_age AGE_RESET = 16'd60;

endpackage

/* hw/rtl/aslt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module aslt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/aslt_age_cmp.sv */
// Shared aging comparator: stamp plus max age, without wrap, below now.
// Depends on aslt_pkg.
module aslt_age_cmp (
    input  aslt_pkg::t_stamp i_stamp,
    input  aslt_pkg::t_age   i_max_age,
    input  aslt_pkg::t_stamp i_now,
    output logic             o_expired
);

    logic [aslt_pkg::STAMP_W:0] w_limit;

    // 33-bit sum so a late stamp never wraps into an early one
    assign w_limit   = {1'b0, i_stamp}
                     + {{(aslt_pkg::STAMP_W + 1 - aslt_pkg::AGE_W){1'b0}}, i_max_age};
    assign o_expired = w_limit < {1'b0, i_now};

endmodule

/* hw/rtl/aging_slot_link_table.sv */
// Aging slot link table: a table of handles with time stamps.
// Input channel (valid/stall) carries add or take requests; output channel
// (valid/stall) returns one word per request. A single write port sets
// max_age; it is to be written only while the block is idle, which the block itself does not enforce.
// Add: the sequencer walks the slots from 0, one slot per cycle, through the
// shared age comparator, emptying expired slots until it finds an empty one,
// where it stores handle and time.
// Take: the request passes through the address, RAM read and result steps.
// One request is in work at a time; o_in_stall is high while it runs, so the
// next request is taken only once the previous one is done. The scan speed is
// set by the single read port of the slot RAM.
// The result sits in an output register, so a new request is accepted while
// a result waits; a request that finishes while the receiver stalls holds
// its last step until the output register frees.
// Reset (synchronous, active low) empties every slot at once through the
// occupancy flags, drops any pending result and sets max_age to 60.
// No clearing pass is needed.
module aging_slot_link_table #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  aslt_pkg::t_age           i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_req_type,
    input  aslt_pkg::t_handle        i_channel_handle,
    input  aslt_pkg::t_stamp         i_now_seconds,
    input  aslt_pkg::t_id            i_slot_id,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [aslt_pkg::IDX_OUT_W-1:0] o_slot_index,
    output logic                     o_table_full,
    output aslt_pkg::t_handle        o_taken_handle
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [aslt_pkg::ID_W:0] SLOT_LIMIT = (aslt_pkg::ID_W + 1)'(SLOT_COUNT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TRD  = 2'd2;
    localparam logic [1:0] S_TDAT = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [IDX_W-1:0]               r_idx, n_idx;
    logic [SLOT_COUNT-1:0]          r_occ, n_occ;
    aslt_pkg::t_age                 r_max_age;
    aslt_pkg::t_handle              r_handle;
    aslt_pkg::t_stamp               r_now;
    aslt_pkg::t_id                  r_id;
    logic                           r_out_valid, n_out_valid;
    logic [aslt_pkg::IDX_OUT_W-1:0] r_slot_index, n_slot_index;
    logic                           r_table_full, n_table_full;
    aslt_pkg::t_handle              r_taken_handle, n_taken_handle;

    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_empty;
    logic                           w_done;
    logic                           w_expired;
    logic                           w_in_range;
    logic [IDX_W-1:0]               w_id_idx;
    logic                           ram_we;
    logic [IDX_W-1:0]               ram_raddr;
    aslt_pkg::t_entry               ram_wdata;
    aslt_pkg::t_entry               ram_rdata;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_empty    = !r_occ[r_idx];
    assign w_done     = w_empty || (r_idx == LAST_IDX);
    assign w_id_idx   = r_id[IDX_W-1:0];
    assign w_in_range = {1'b0, r_id} < SLOT_LIMIT;
    assign ram_wdata  = '{handle: r_handle, stamp: r_now};

    aslt_ram #(
        .WIDTH ($bits(aslt_pkg::t_entry)),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    aslt_age_cmp u_age (
        .i_stamp   (ram_rdata.stamp),
        .i_max_age (r_max_age),
        .i_now     (r_now),
        .o_expired (w_expired)
    );

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_occ          = r_occ;
        n_out_valid    = r_out_valid;
        n_slot_index   = r_slot_index;
        n_table_full   = r_table_full;
        n_taken_handle = r_taken_handle;
        ram_we         = 1'b0;
        ram_raddr      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // slot 0 is read every idle cycle so the scan starts with data
                if (w_accept) begin
                    n_idx   = '0;
                    n_state = (i_req_type == aslt_pkg::REQ_TAKE) ? S_TRD : S_SCAN;
                end
            end
            S_SCAN: begin
                // re-read the current slot while the result is held back
                ram_raddr = r_idx;
                if (!w_done || w_out_free) begin
                    ram_raddr = r_idx + IDX_W'(1);
                    if (w_empty) begin
                        ram_we         = 1'b1;
                        n_occ[r_idx]   = (r_handle != '0);
                        n_out_valid    = 1'b1;
                        n_slot_index   = aslt_pkg::IDX_OUT_W'(r_idx);
                        n_table_full   = 1'b0;
                        n_taken_handle = '0;
                        n_state        = S_IDLE;
                    end else begin
                        if (w_expired) begin
                            n_occ[r_idx] = 1'b0;
                        end
                        if (r_idx == LAST_IDX) begin
                            n_out_valid    = 1'b1;
                            n_slot_index   = '0;
                            n_table_full   = 1'b1;
                            n_taken_handle = '0;
                            n_state        = S_IDLE;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end
                end
            end
            S_TRD: begin
                ram_raddr = w_id_idx;
                n_state   = S_TDAT;
            end
            S_TDAT: begin
                ram_raddr = w_id_idx;
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_slot_index   = '0;
                    n_table_full   = 1'b0;
                    n_taken_handle = (w_in_range && r_occ[w_id_idx]) ? ram_rdata.handle : '0;
                    if (w_in_range) begin
                        n_occ[w_id_idx] = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            r_max_age   <= aslt_pkg::AGE_RESET;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_handle <= i_channel_handle;
            r_now    <= i_now_seconds;
            r_id     <= i_slot_id;
        end
        r_slot_index   <= n_slot_index;
        r_table_full   <= n_table_full;
        r_taken_handle <= n_taken_handle;
    end

    assign o_out_valid    = r_out_valid;
    assign o_slot_index   = r_slot_index;
    assign o_table_full   = r_table_full;
    assign o_taken_handle = r_taken_handle;

endmodule

/* hw/rtl/aslt_checker.sv */
// Port-level checks for the aging slot link table, bound to the top level.
// Depends on aslt_pkg and aging_slot_link_table_defines.svh.
`include "aging_slot_link_table_defines.svh"

module aslt_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [aslt_pkg::IDX_OUT_W-1:0] o_slot_index,
    input logic                     o_table_full,
    input aslt_pkg::t_handle        o_taken_handle
);

    `ASLT_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_slot_index) && $stable(o_table_full) && $stable(o_taken_handle), "stalled output word changed")

    `ASLT_ASSERT(a_busy_after_accept, i_in_valid && !o_in_stall |=> o_in_stall, "block not busy after accepting a word")

    `ASLT_ASSERT(a_full_clean, o_out_valid && o_table_full |-> o_slot_index == '0 && o_taken_handle == '0, "full result carries index or handle")

    `ASLT_ASSERT(a_take_clean, o_out_valid && o_taken_handle != '0 |-> !o_table_full && o_slot_index == '0, "take result carries add fields")

    `ASLT_ASSERT_ALWAYS(a_reset_drop, !i_rst_n |=> !o_out_valid, "output word survived reset")

endmodule

bind aging_slot_link_table aslt_checker u_aslt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_slot_index   (o_slot_index),
    .o_table_full   (o_table_full),
    .o_taken_handle (o_taken_handle)
);

/* tb/aging_slot_link_table_tb.sv */
// Testbench for aging_slot_link_table: directed and random add/take traffic
// checked against a shadow table with aging. Depends on aslt_pkg and the RTL.
// Self-checking; needs no files or arguments.
module aging_slot_link_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [aslt_pkg::IDX_OUT_W-1:0] slot_idx;
        logic                           full;
        aslt_pkg::t_handle              taken;
    } t_word;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    aslt_pkg::t_age                 i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_req_type = aslt_pkg::REQ_ADD;
    aslt_pkg::t_handle              i_channel_handle = '0;
    aslt_pkg::t_stamp               i_now_seconds = '0;
    aslt_pkg::t_id                  i_slot_id = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [aslt_pkg::IDX_OUT_W-1:0] o_slot_index;
    logic                           o_table_full;
    aslt_pkg::t_handle              o_taken_handle;

    // shadow copy of the table
    aslt_pkg::t_handle shadow_handle [SLOTS];
    aslt_pkg::t_stamp  shadow_stamp [SLOTS];
    aslt_pkg::t_age    shadow_age;
    aslt_pkg::t_stamp  clock_now;

    t_word   due_words [$];

    bit      in_idle_on = 1'b1;
    bit      out_idle_on = 1'b1;
    int      hold_req = 0;

    int unsigned mismatches = 0;
    int unsigned n_adds = 0;
    int unsigned n_full = 0;
    int unsigned n_aged = 0;
    int unsigned n_takes = 0;
    int unsigned n_hits = 0;
    int unsigned n_ages = 0;
    int unsigned n_holds = 0;

    aging_slot_link_table #(.SLOT_COUNT(SLOTS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_channel_handle (i_channel_handle),
        .i_now_seconds    (i_now_seconds),
        .i_slot_id        (i_slot_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_slot_index     (o_slot_index),
        .o_table_full     (o_table_full),
        .o_taken_handle   (o_taken_handle)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Apply one request to the shadow table and return the word it yields.
    function automatic t_word apply_request(input logic req,
                                            input aslt_pkg::t_handle h,
                                            input aslt_pkg::t_stamp now,
                                            input aslt_pkg::t_id id);
        t_word                      w;
        logic [aslt_pkg::STAMP_W:0] reach;
        logic [aslt_pkg::STAMP_W:0] age_ext;
        bit                         placed;
        int                         k;
        w = '0;
        placed = 1'b0;
        age_ext = shadow_age;
        if (req == aslt_pkg::REQ_ADD) begin
            n_adds++;
            for (k = 0; k < SLOTS; k++) begin
                if (!placed) begin
                    if (shadow_handle[k] == '0) begin
                        shadow_handle[k] = h;
                        shadow_stamp[k] = now;
                        w.slot_idx = k[aslt_pkg::IDX_OUT_W-1:0];
                        placed = 1'b1;
                    end else begin
                        // 33-bit sum, no wrap
                        reach = {1'b0, shadow_stamp[k]} + age_ext;
                        if (reach < {1'b0, now}) begin
                            shadow_handle[k] = '0;
                            n_aged++;
                        end
                    end
                end
            end
            if (!placed) begin
                w.full = 1'b1;
                n_full++;
            end
        end else begin
            n_takes++;
            if (id < SLOTS) begin
                w.taken = shadow_handle[id];
                shadow_handle[id] = '0;
                if (w.taken != '0) n_hits++;
            end
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic aslt_pkg::t_handle next_handle();
        aslt_pkg::t_handle h;
        h = $urandom;
        if ($urandom_range(0, 29) == 0) h = '0;
        else if (h == '0) h = 32'h1;
        return h;
    endfunction

    function automatic aslt_pkg::t_id pick_busy_slot();
        int busy [$];
        int k;
        for (k = 0; k < SLOTS; k++)
            if (shadow_handle[k] != '0) busy.push_back(k);
        if (busy.size() == 0) return aslt_pkg::t_id'($urandom_range(0, SLOTS - 1));
        return aslt_pkg::t_id'(busy[$urandom_range(0, busy.size() - 1)]);
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t on %s: expected %h, got %h",
                     $realtime, what, want, got);
    endfunction

    task automatic check_word();
        t_word w;
        if (due_words.size() == 0) begin
            note_mismatch("word with nothing outstanding", '0, o_taken_handle);
        end else begin
            w = due_words.pop_front();
            if (o_slot_index !== w.slot_idx)
                note_mismatch("slot_index", 32'(w.slot_idx), 32'(o_slot_index));
            if (o_table_full !== w.full)
                note_mismatch("table_full", 32'(w.full), 32'(o_table_full));
            if (o_taken_handle !== w.taken)
                note_mismatch("taken_handle", w.taken, o_taken_handle);
        end
    endtask

    // Result side: check accepted words, drive random stall and the long hold-off.
    initial begin : result_side
        int stall_run;
        int free_run;
        stall_run = 0;
        free_run = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_word();
            if (hold_req > 0) begin
                stall_run = hold_req;
                hold_req = 0;
                n_holds++;
            end else if (stall_run == 0 && free_run == 0 && out_idle_on) begin
                stall_run = pick_gap();
                free_run = $urandom_range(0, 6);
            end
            if (stall_run > 0) begin
                i_out_stall <= 1'b1;
                stall_run--;
            end else begin
                i_out_stall <= 1'b0;
                if (free_run > 0) free_run--;
            end
        end
    end

    // Offer one request and hold it until accepted; valid stays high for the next one.
    task automatic send_word(input logic req, input aslt_pkg::t_handle h,
                             input aslt_pkg::t_stamp now, input aslt_pkg::t_id id);
        int gap;
        gap = in_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_channel_handle <= h;
        i_now_seconds <= now;
        i_slot_id <= id;
        do @(posedge i_clk); while (o_in_stall);
        due_words.push_back(apply_request(req, h, now, id));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_max_age(input aslt_pkg::t_age v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_age = v;
        n_ages++;
    endtask

    task automatic test_take_corners();
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd0);
        send_word(aslt_pkg::REQ_TAKE, '1, '1, 8'd31);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd32);
        send_word(aslt_pkg::REQ_TAKE, '1, '1, 8'd255);
    endtask

    task automatic test_add_corners();
        // zero handle leaves the slot empty
        send_word(aslt_pkg::REQ_ADD, '0, '0, 8'd0);
        send_word(aslt_pkg::REQ_ADD, '1, '1, 8'd255);
        // stamp at the top of the range must not wrap when aged
        send_word(aslt_pkg::REQ_ADD, 32'h8000_0001, '1, 8'd0);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd0);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd1);
    endtask

    task automatic test_age_boundary();
        send_word(aslt_pkg::REQ_ADD, 32'h0000_00A1, 32'd100, 8'd0);
        send_word(aslt_pkg::REQ_ADD, 32'h0000_00B2, 32'd160, 8'd0);
        send_word(aslt_pkg::REQ_ADD, 32'h0000_00C3, 32'd161, 8'd0);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd0);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd1);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd2);
    endtask

    task automatic test_age_zero();
        set_max_age(16'd0);
        send_word(aslt_pkg::REQ_ADD, 32'h0000_0D00, 32'd500, 8'd0);
        send_word(aslt_pkg::REQ_ADD, 32'h0000_0E00, 32'd500, 8'd0);
        send_word(aslt_pkg::REQ_ADD, 32'h0000_0F00, 32'd501, 8'd0);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd2);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd0);
    endtask

    task automatic test_table_full();
        int k;
        set_max_age(16'hFFFF);
        for (k = 0; k < SLOTS; k++)
            send_word(aslt_pkg::REQ_ADD, $urandom | 32'h1, 32'd2000 + k, aslt_pkg::t_id'(k));
        send_word(aslt_pkg::REQ_ADD, $urandom | 32'h1, 32'd2100, 8'd0);
        // every slot ages out in one scan, yet nothing is stored
        set_max_age(16'd0);
        send_word(aslt_pkg::REQ_ADD, $urandom | 32'h1, 32'd2100, 8'd0);
        send_word(aslt_pkg::REQ_ADD, $urandom | 32'h1, 32'd2101, 8'd0);
        send_word(aslt_pkg::REQ_TAKE, '0, '0, 8'd0);
    endtask

    task automatic test_receiver_holdoff();
        int k;
        in_idle_on = 1'b0;
        hold_req = HOLD_CYCLES;
        for (k = 0; k < 12; k++) begin
            if (k % 3 == 2)
                send_word(aslt_pkg::REQ_TAKE, $urandom, $urandom, pick_busy_slot());
            else
                send_word(aslt_pkg::REQ_ADD, next_handle(), clock_now + k,
                          aslt_pkg::t_id'($urandom));
        end
        wait_idle();
        in_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int count);
        int i;
        int pick;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 29) == 0)
                    clock_now = clock_now + shadow_age + $urandom_range(1, 50);
                else
                    clock_now = clock_now + $urandom_range(0, shadow_age / 8 + 2);
                send_word(aslt_pkg::REQ_ADD, next_handle(), clock_now,
                          aslt_pkg::t_id'($urandom));
            end else if (pick < 88) begin
                send_word(aslt_pkg::REQ_TAKE, $urandom, $urandom, pick_busy_slot());
            end else if (pick < 94) begin
                send_word(aslt_pkg::REQ_TAKE, $urandom, $urandom,
                          aslt_pkg::t_id'($urandom_range(0, 255)));
            end else begin
                send_word(aslt_pkg::REQ_ADD, next_handle(), $urandom,
                          aslt_pkg::t_id'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int k;
        for (k = 0; k < SLOTS; k++) begin
            shadow_handle[k] = '0;
            shadow_stamp[k] = '0;
        end
        shadow_age = aslt_pkg::AGE_RESET;
        clock_now = 32'd3000;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_take_corners();
        test_add_corners();
        test_age_boundary();
        test_age_zero();
        test_table_full();
        test_receiver_holdoff();

        set_max_age(16'hFFFF);
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        clock_now = $urandom;
        test_random_traffic(120);

        set_max_age(aslt_pkg::t_age'($urandom));
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        test_random_traffic(130);

        set_max_age(16'd1);
        clock_now = $urandom;
        test_random_traffic(120);

        set_max_age(aslt_pkg::AGE_RESET);
        out_idle_on = 1'b0;
        test_random_traffic(130);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d adds (%0d hit a full table, %0d slots aged out),",
                 n_adds, n_full, n_aged);
        $display("%0d takes (%0d with a handle), max_age written %0d times, %0d hold-off",
                 n_takes, n_hits, n_ages, n_holds);
        if (mismatches == 0 && due_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
